// ===== hdl/swap_slot_table_defines.svh =====
// Assertion macros for the swap slot table checker.
`ifndef SWAP_SLOT_TABLE_DEFINES_SVH
`define SWAP_SLOT_TABLE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SST_ASSERT_ACTIVE(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sst_pkg.sv =====
// Types and codes shared by the swap slot table modules.
package sst_pkg;

   localparam logic [1:0] REQ_LOOKUP  = 2'd0;
   localparam logic [1:0] REQ_STORE   = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_STORE,
      OP_RELEASE,
      OP_NOP
   } cmd_op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [14:0] owner_pid;
      logic [31:0] page_addr;
      logic [9:0]  slot_in;
   } sst_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] slot_out;
   } sst_rsp_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [14:0] owner_pid;
      logic [31:0] page_addr;
      logic [9:0]  slot;
   } sst_cmd_type;

   typedef struct packed {
      logic        valid;
      logic [14:0] owner_pid;
      logic [31:0] page_addr;
   } sst_entry_type;

endpackage

// ===== hdl/swap_slot_table.sv =====
// Swap slot table top level: request decode, command queue and scan engine.
// A lookup hit or a store into slot j strobes its result once the scan has read slot j;
// a miss or full store, after the last slot; release and unused codes skip the scan.
// Throughput is set by the single read port of the slot memory: one slot per cycle.
// A two-entry queue lets up to two further requests transfer while a scan runs.
// After reset a clearing pass over all SLOTS slots empties the table; busy is high then.
module swap_slot_table #(
   parameter int SLOTS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sst_pkg::sst_req_type req_item,
   output logic                 rsp_valid,
   output sst_pkg::sst_rsp_type rsp_item
);
   import sst_pkg::*;

   logic        push;
   sst_cmd_type push_cmd;
   sst_cmd_type head;
   logic        pop;
   logic        q_empty;
   logic        q_full;
   logic        clearing;

   // Hold requests off while the table is cleared or the queue has no room.
   assign busy = clearing || q_full;

   // Classify each transfer; an out-of-range release becomes a no-op here.
   sst_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .start (start),
      .busy  (busy),
      .req   (req_item),
      .push  (push),
      .cmd   (push_cmd)
   );

   // Decouple decode from the scan so either side may stall on its own.
   sst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Walk the slot memory from slot zero, stop at the first hit, drive the result.
   sst_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_item)
   );

endmodule

// ===== hdl/sst_front.sv =====
// Request decode: classify each accepted request into a back-end command.
module sst_front #(
   parameter int SLOTS = 1024
) (
   input  logic                start,
   input  logic                busy,
   input  sst_pkg::sst_req_type req,
   output logic                push,
   output sst_pkg::sst_cmd_type cmd
);
   import sst_pkg::*;

   logic in_range;

   // A release beyond the table end degrades to a no-op.
   assign in_range = ({7'b0, req.slot_in} < 17'(SLOTS));
   assign push     = start && !busy;

   always_comb begin
      cmd.owner_pid = req.owner_pid;
      cmd.page_addr = req.page_addr;
      cmd.slot      = req.slot_in;
      unique case (req.req_type)
         REQ_LOOKUP:  cmd.op = OP_LOOKUP;
         REQ_STORE:   cmd.op = OP_STORE;
         REQ_RELEASE: cmd.op = in_range ? OP_RELEASE : OP_NOP;
         default:     cmd.op = OP_NOP;
      endcase
   end

endmodule

// ===== hdl/sst_queue.sv =====
// Two-entry command queue between request decode and the scan engine.
module sst_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sst_pkg::sst_cmd_type push_data,
   input  logic                 pop,
   output sst_pkg::sst_cmd_type head,
   output logic                 empty,
   output logic                 full
);
   import sst_pkg::*;

   sst_cmd_type       entries_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/sst_back.sv =====
// Scan engine: slot memory, clearing pass and sequential first-match search.
module sst_back #(
   parameter int SLOTS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sst_pkg::sst_cmd_type head,
   input  logic                 q_empty,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output sst_pkg::sst_rsp_type rsp
);
   import sst_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN
   } state_type;

   sst_entry_type   mem [SLOTS];
   sst_entry_type   rd_data_ff;
   logic            wr_en;
   logic [SW-1:0]   wr_addr;
   sst_entry_type   wr_data;

   state_type       state_ff, state_in;
   logic [SW-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [SW-1:0]   issue_ptr_ff, issue_ptr_in;
   logic            issue_on_ff, issue_on_in;
   logic            rd_vld_ff, rd_vld_in;
   logic [SW-1:0]   rd_idx_ff, rd_idx_in;
   sst_cmd_type     cmd_ff, cmd_in;
   logic            rsp_valid_ff, rsp_valid_in;
   sst_rsp_type     rsp_ff, rsp_in;

   logic [SW+9:0]   rel_wide;
   logic [SW+9:0]   idx_wide;
   logic            match, hit;

   assign rel_wide = {{SW{1'b0}}, head.slot};
   assign idx_wide = {{10{1'b0}}, rd_idx_ff};

   assign match = rd_data_ff.valid
               && (rd_data_ff.owner_pid == cmd_ff.owner_pid)
               && (rd_data_ff.page_addr == cmd_ff.page_addr);
   assign hit   = rd_vld_ff && ((cmd_ff.op == OP_STORE) ? !rd_data_ff.valid : match);

   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[issue_ptr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      issue_ptr_in = issue_ptr_ff;
      issue_on_in  = issue_on_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = issue_ptr_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: ST_DONE, slot_out: 10'd0};
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_ptr_ff;
      wr_data      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ptr_ff == LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               unique case (head.op)
                  OP_LOOKUP, OP_STORE: begin
                     cmd_in       = head;
                     issue_ptr_in = '0;
                     issue_on_in  = 1'b1;
                     state_in     = S_SCAN;
                  end
                  OP_RELEASE: begin
                     wr_en        = 1'b1;
                     wr_addr      = rel_wide[SW-1:0];
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               rsp_valid_in    = 1'b1;
               rsp_in.slot_out = idx_wide[9:0];
               issue_on_in     = 1'b0;
               state_in        = S_IDLE;
               if (cmd_ff.op == OP_STORE) begin
                  wr_en   = 1'b1;
                  wr_addr = rd_idx_ff;
                  wr_data = '{valid: 1'b1, owner_pid: cmd_ff.owner_pid,
                              page_addr: cmd_ff.page_addr};
               end
            end else if (rd_vld_ff && (rd_idx_ff == LAST)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = (cmd_ff.op == OP_STORE) ? ST_FULL : ST_MISS;
               issue_on_in   = 1'b0;
               state_in      = S_IDLE;
            end else if (issue_on_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ptr_ff;
               if (issue_ptr_ff == LAST) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_ptr_in = issue_ptr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         issue_on_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         issue_on_ff  <= issue_on_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ptr_ff <= issue_ptr_in;
      rd_idx_ff    <= rd_idx_in;
      cmd_ff       <= cmd_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// ===== hdl/sst_checker.sv =====
// Port-level checks on the swap slot table, bound to the top level.
`include "swap_slot_table_defines.svh"

module sst_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 busy,
   input logic                 rsp_valid,
   input sst_pkg::sst_rsp_type rsp_item
);
   import sst_pkg::*;

   `SST_ASSERT_ACTIVE(a_status_code, clock, reset,
      rsp_valid |-> (rsp_item.status == ST_DONE || rsp_item.status == ST_MISS ||
                     rsp_item.status == ST_FULL), "undefined status code")
   `SST_ASSERT_ACTIVE(a_slot_zero, clock, reset,
      (rsp_valid && rsp_item.status != ST_DONE) |-> (rsp_item.slot_out == 10'd0),
      "slot not zero on miss or full")
   `SST_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy,
      "not busy during clearing pass")
   `SST_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_valid,
      "result strobe straight after reset")

endmodule

bind swap_slot_table sst_checker u_sst_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
